### sv/lfpd_pkg.sv
// Package for the line-follow PID drive: field widths, constants, register
// indexes and the structures shared between the pipeline stages.
// No dependencies.
package lfpd_pkg;

    localparam int unsigned SENSOR_COUNT_DEF = 8;
    localparam int unsigned MAX_SENSORS      = 8;

    localparam int unsigned POS_W      = 13;
    localparam int unsigned LEVEL_W    = 10;
    localparam int unsigned GAIN_W     = 18;
    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned OFFSET_W   = 8;
    localparam int unsigned CORR_W     = 9;
    localparam int unsigned ERR_W      = 13;
    localparam int unsigned INTEG_W    = 11;
    localparam int unsigned PROD_W     = 33;
    localparam int unsigned ACC_W      = 35;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    localparam int unsigned POS_MAX      = 7000;
    localparam int unsigned POS_CENTER   = 3500;
    localparam int unsigned LEVEL_THRESH = 500;
    localparam int unsigned INTEG_LIMIT  = 600;
    localparam int unsigned CORR_LIMIT   = 150;
    localparam int unsigned BASE_FAST    = 200;
    localparam int unsigned BASE_MID     = 160;
    localparam int unsigned BASE_SLOW    = 120;
    localparam int unsigned ERR_NEAR     = 200;
    localparam int unsigned ERR_FAR      = 2000;
    localparam int unsigned TURN_HIGH    = 120;
    localparam int unsigned TURN_LOW     = 60;

    localparam int unsigned GAIN_PROP_RST  = 22938;
    localparam int unsigned GAIN_INTEG_RST = 20;
    localparam int unsigned GAIN_DERIV_RST = 13107;
    localparam int unsigned MAX_SPEED_RST  = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP    = 3'd0,
        REG_GAIN_INTEG   = 3'd1,
        REG_GAIN_DERIV   = 3'd2,
        REG_MAX_SPEED    = 3'd3,
        REG_OFFSET_LEFT  = 3'd4,
        REG_OFFSET_RIGHT = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]          gain_prop;
        logic [GAIN_W-1:0]          gain_integ;
        logic [GAIN_W-1:0]          gain_deriv;
        logic [SPEED_W-1:0]         max_speed;
        logic signed [OFFSET_W-1:0] offset_left;
        logic signed [OFFSET_W-1:0] offset_right;
    } cfg_t;

    typedef struct packed {
        logic                     lost;
        logic                     turn_right;
        logic [SPEED_W-1:0]       base;
        logic signed [PROD_W-1:0] prod_p;
        logic signed [PROD_W-1:0] prod_i;
        logic signed [PROD_W-1:0] prod_d;
    } pid_stage_t;

endpackage

### sv/lfpd_if.sv
// Channel interfaces of the line-follow PID drive: scan requests in and
// drive results out, each with valid, ready and payload.
// Depends on lfpd_pkg.
interface lfpd_scan_if;
    logic                          valid;
    logic                          ready;
    logic [lfpd_pkg::POS_W-1:0]    position;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_0;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_1;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_2;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_3;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_4;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_5;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_6;
    logic [lfpd_pkg::LEVEL_W-1:0]  level_7;

    modport source (
        output valid, position, level_0, level_1, level_2, level_3,
               level_4, level_5, level_6, level_7,
        input  ready
    );
    modport sink (
        input  valid, position, level_0, level_1, level_2, level_3,
               level_4, level_5, level_6, level_7,
        output ready
    );
endinterface

interface lfpd_drive_if;
    logic                                valid;
    logic                                ready;
    logic [lfpd_pkg::SPEED_W-1:0]        left_drive;
    logic [lfpd_pkg::SPEED_W-1:0]        right_drive;
    logic                                line_lost;
    logic signed [lfpd_pkg::CORR_W-1:0]  correction;

    modport source (
        output valid, left_drive, right_drive, line_lost, correction,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, line_lost, correction,
        output ready
    );
endinterface

### sv/lfpd_cfg_regs.sv
// Configuration register bank of the line-follow PID drive: gains, speed
// limit and motor offsets, written through a plain write port.
// Depends on lfpd_pkg.
module lfpd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lfpd_pkg::cfg_t                    cfg
);
    import lfpd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop    <= GAIN_W'(GAIN_PROP_RST);
            cfg_reg.gain_integ   <= GAIN_W'(GAIN_INTEG_RST);
            cfg_reg.gain_deriv   <= GAIN_W'(GAIN_DERIV_RST);
            cfg_reg.max_speed    <= SPEED_W'(MAX_SPEED_RST);
            cfg_reg.offset_left  <= '0;
            cfg_reg.offset_right <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GAIN_PROP:    cfg_reg.gain_prop    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG:   cfg_reg.gain_integ   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:   cfg_reg.gain_deriv   <= cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:    cfg_reg.max_speed    <= cfg_data[SPEED_W-1:0];
                REG_OFFSET_LEFT:  cfg_reg.offset_left  <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_OFFSET_RIGHT: cfg_reg.offset_right <= $signed(cfg_data[OFFSET_W-1:0]);
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/lfpd_err_stage.sv
// Front stages of the line-follow PID drive: the scan input register, the
// error, line-lost and integral logic with the loop state, and the product register.
// Depends on lfpd_pkg and lfpd_if.
module lfpd_err_stage #(
    parameter int unsigned SENSOR_COUNT = lfpd_pkg::SENSOR_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfpd_pkg::cfg_t          cfg,
    lfpd_scan_if.sink               scan,
    input  logic                    next_ready,
    output logic                    pid_valid,
    output lfpd_pkg::pid_stage_t    pid
);
    import lfpd_pkg::*;

    localparam int unsigned CNT_W = $clog2(SENSOR_COUNT + 1);

    logic                       scan_valid_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [LEVEL_W-1:0]         level_reg [SENSOR_COUNT];
    logic [LEVEL_W-1:0]         level_in  [MAX_SENSORS];

    logic signed [ERR_W-1:0]    last_err_reg;
    logic signed [INTEG_W-1:0]  integ_reg;

    logic                       pid_valid_reg;
    pid_stage_t                 pid_reg;

    logic                       scan_adv;
    logic                       pid_adv;
    logic [POS_W-1:0]           pos_sat;
    logic signed [ERR_W:0]      err_wide;
    logic signed [ERR_W-1:0]    err_c;
    logic [CNT_W-1:0]           active_cnt;
    logic                       lost_c;
    logic signed [ERR_W:0]      integ_sum_c;
    logic signed [INTEG_W-1:0]  integ_new;
    logic signed [ERR_W:0]      deriv_c;
    logic signed [ERR_W-1:0]    mag_c;
    logic [SPEED_W-1:0]         base_c;
    pid_stage_t                 pid_c;

    assign pid_adv    = !pid_valid_reg || next_ready;
    assign scan_adv   = !scan_valid_reg || pid_adv;
    assign scan.ready = scan_adv;

    always_comb
    begin
        level_in[0] = scan.level_0;
        level_in[1] = scan.level_1;
        level_in[2] = scan.level_2;
        level_in[3] = scan.level_3;
        level_in[4] = scan.level_4;
        level_in[5] = scan.level_5;
        level_in[6] = scan.level_6;
        level_in[7] = scan.level_7;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_adv)
        begin
            scan_valid_reg <= scan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_adv && scan.valid)
        begin
            pos_reg <= scan.position;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                level_reg[i] <= level_in[i];
            end
        end
    end

    always_comb
    begin
        pos_sat  = (pos_reg > POS_W'(POS_MAX)) ? POS_W'(POS_MAX) : pos_reg;
        err_wide = $signed({1'b0, pos_sat}) - $signed((ERR_W + 1)'(POS_CENTER));
        err_c    = err_wide[ERR_W-1:0];

        active_cnt = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (level_reg[i] > LEVEL_W'(LEVEL_THRESH))
            begin
                active_cnt = active_cnt + CNT_W'(1);
            end
        end
        lost_c = (active_cnt < CNT_W'(2));

        integ_sum_c = (ERR_W + 1)'(integ_reg) + (ERR_W + 1)'(err_c);
        if (integ_sum_c > $signed((ERR_W + 1)'(INTEG_LIMIT)))
        begin
            integ_new = $signed(INTEG_W'(INTEG_LIMIT));
        end
        else if (integ_sum_c < -$signed((ERR_W + 1)'(INTEG_LIMIT)))
        begin
            integ_new = -$signed(INTEG_W'(INTEG_LIMIT));
        end
        else
        begin
            integ_new = integ_sum_c[INTEG_W-1:0];
        end

        deriv_c = (ERR_W + 1)'(err_c) - (ERR_W + 1)'(last_err_reg);

        mag_c = err_c[ERR_W-1] ? -err_c : err_c;
        if (mag_c < $signed(ERR_W'(ERR_NEAR)))
        begin
            base_c = SPEED_W'(BASE_FAST);
        end
        else if (mag_c > $signed(ERR_W'(ERR_FAR)))
        begin
            base_c = SPEED_W'(BASE_SLOW);
        end
        else
        begin
            base_c = SPEED_W'(BASE_MID);
        end

        pid_c.lost       = lost_c;
        pid_c.turn_right = (last_err_reg > 0);
        pid_c.base       = base_c;
        pid_c.prod_p     = PROD_W'($signed({1'b0, cfg.gain_prop}))  * PROD_W'(err_c);
        pid_c.prod_i     = PROD_W'($signed({1'b0, cfg.gain_integ})) * PROD_W'(integ_new);
        pid_c.prod_d     = PROD_W'($signed({1'b0, cfg.gain_deriv})) * PROD_W'(deriv_c);
    end

    // The loop state moves only when a tracked scan passes into the product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            integ_reg     <= '0;
            pid_valid_reg <= 1'b0;
        end
        else if (pid_adv)
        begin
            pid_valid_reg <= scan_valid_reg;
            if (scan_valid_reg && !lost_c)
            begin
                last_err_reg <= err_c;
                integ_reg    <= integ_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pid_adv && scan_valid_reg)
        begin
            pid_reg <= pid_c;
        end
    end

    assign pid_valid = pid_valid_reg;
    assign pid       = pid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= $signed(INTEG_W'(INTEG_LIMIT)))
        && (integ_reg >= -$signed(INTEG_W'(INTEG_LIMIT))))
        else $error("Integral state left its saturation range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!scan_valid_reg || !pid_adv || lost_c)
        |=> ($stable(integ_reg) && $stable(last_err_reg)))
        else $error("Loop state changed without a tracked scan passing.");

endmodule

### sv/lfpd_mix_stage.sv
// Back stage of the line-follow PID drive: sums the products, scales and saturates the
// correction, mixes (or turns if lost) and clamps the drives into the result register.
// Depends on lfpd_pkg and lfpd_if.
module lfpd_mix_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfpd_pkg::cfg_t          cfg,
    input  logic                    pid_valid,
    input  lfpd_pkg::pid_stage_t    pid,
    output logic                    next_ready,
    lfpd_drive_if.source            drive
);
    import lfpd_pkg::*;

    localparam int unsigned Q_W   = ACC_W - FRAC_BITS;
    localparam int unsigned RAW_W = SPEED_W + 3;
    localparam int unsigned RND   = (2 ** FRAC_BITS) - 1;

    logic                       out_valid_reg;
    logic [SPEED_W-1:0]         left_reg;
    logic [SPEED_W-1:0]         right_reg;
    logic                       lost_reg;
    logic signed [CORR_W-1:0]   corr_reg;

    logic                       out_adv;
    logic signed [ACC_W-1:0]    acc_c;
    logic signed [ACC_W-1:0]    acc_adj;
    logic signed [Q_W-1:0]      q_c;
    logic signed [Q_W-1:0]      q_lim;
    logic signed [CORR_W-1:0]   corr_c;
    logic signed [RAW_W-1:0]    base_s;
    logic signed [RAW_W-1:0]    corr_s;
    logic signed [RAW_W-1:0]    raw_left;
    logic signed [RAW_W-1:0]    raw_right;
    logic [SPEED_W-1:0]         left_c;
    logic [SPEED_W-1:0]         right_c;

    // Clamps a raw speed to the drive range, adds the motor offset and clamps again.
    function automatic logic [SPEED_W-1:0] drive_limit(
        input logic signed [RAW_W-1:0]    raw,
        input logic [SPEED_W-1:0]         max_s,
        input logic signed [OFFSET_W-1:0] off
    );
        logic [SPEED_W-1:0]      v1;
        logic signed [RAW_W-1:0] v2;
        logic signed [RAW_W-1:0] max_w;
        logic [SPEED_W-1:0]      res;
        max_w = $signed(RAW_W'(max_s));
        if (raw < 0)
        begin
            v1 = '0;
        end
        else if (raw > max_w)
        begin
            v1 = max_s;
        end
        else
        begin
            v1 = raw[SPEED_W-1:0];
        end
        v2 = $signed(RAW_W'(v1)) + RAW_W'(off);
        if (v2 < 0)
        begin
            res = '0;
        end
        else if (v2 > max_w)
        begin
            res = max_s;
        end
        else
        begin
            res = v2[SPEED_W-1:0];
        end
        return res;
    endfunction

    assign out_adv    = !out_valid_reg || drive.ready;
    assign next_ready = out_adv;

    always_comb
    begin
        acc_c   = ACC_W'(pid.prod_p) + ACC_W'(pid.prod_i) + ACC_W'(pid.prod_d);
        // Bias negative sums so the arithmetic shift truncates toward zero.
        acc_adj = acc_c + (acc_c[ACC_W-1] ? $signed(ACC_W'(RND)) : $signed(ACC_W'(0)));
        q_c     = Q_W'(acc_adj >>> FRAC_BITS);

        if (q_c > $signed(Q_W'(CORR_LIMIT)))
        begin
            q_lim = $signed(Q_W'(CORR_LIMIT));
        end
        else if (q_c < -$signed(Q_W'(CORR_LIMIT)))
        begin
            q_lim = -$signed(Q_W'(CORR_LIMIT));
        end
        else
        begin
            q_lim = q_c;
        end
        corr_c = pid.lost ? '0 : q_lim[CORR_W-1:0];

        base_s = $signed(RAW_W'(pid.base));
        corr_s = RAW_W'(corr_c);
        if (pid.lost)
        begin
            raw_left  = $signed(RAW_W'(pid.turn_right ? TURN_HIGH : TURN_LOW));
            raw_right = $signed(RAW_W'(pid.turn_right ? TURN_LOW : TURN_HIGH));
        end
        else
        begin
            raw_left  = base_s + corr_s;
            raw_right = base_s - corr_s;
        end

        left_c  = drive_limit(raw_left, cfg.max_speed, cfg.offset_left);
        right_c = drive_limit(raw_right, cfg.max_speed, cfg.offset_right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= pid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && pid_valid)
        begin
            left_reg  <= left_c;
            right_reg <= right_c;
            lost_reg  <= pid.lost;
            corr_reg  <= corr_c;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.left_drive  = left_reg;
    assign drive.right_drive = right_reg;
    assign drive.line_lost   = lost_reg;
    assign drive.correction  = corr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && lost_reg) |-> (corr_reg == '0))
        else $error("Correction is not zero on a lost-line result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((corr_reg <= $signed(CORR_W'(CORR_LIMIT)))
        && (corr_reg >= -$signed(CORR_W'(CORR_LIMIT)))))
        else $error("Correction outside its saturation range.");

endmodule

### sv/line_follow_pid_drive.sv
// Line-follow PID drive, top level. A scan request passes through the input register, the
// product register and the result register. Throughput: one scan per cycle while results
// are taken; the integral and last-error loop closes at the product register.
// Reset: configuration returns to its defaults, integral and last error clear to zero,
// and the pipeline empties. Depends on lfpd_pkg, lfpd_if and the lfpd stage modules.
module line_follow_pid_drive #(
    parameter int unsigned SENSOR_COUNT = lfpd_pkg::SENSOR_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    lfpd_scan_if.sink                         scan,
    lfpd_drive_if.source                      drive
);
    import lfpd_pkg::*;

    cfg_t       cfg;
    logic       pid_valid;
    pid_stage_t pid;
    logic       mix_ready;

    lfpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfpd_err_stage #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_err_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .scan       (scan),
        .next_ready (mix_ready),
        .pid_valid  (pid_valid),
        .pid        (pid)
    );

    lfpd_mix_stage u_mix_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pid_valid  (pid_valid),
        .pid        (pid),
        .next_ready (mix_ready),
        .drive      (drive)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !drive.valid |-> scan.ready)
        else $error("Scan requests refused while the result register is empty.");

endmodule
